### design/sss_pkg.sv
// Shared widths and controller/datapath interface types for sample sequence statistics.
`timescale 1ns / 1ps

package sss_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int TIME_W     = 24;
    localparam int INTEGRAL_W = 40;
    localparam int S_TDATA_W  = ((TIME_W + SAMPLE_W + 7) / 8) * 8;

    typedef struct packed {
        logic take;     // sample beat accepted
        logic launch;   // start the mean division
        logic publish;  // load the result register and close the record
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } status_t;

endpackage

### design/sss_divider.sv
// Iterative restoring divider, signed dividend by unsigned divisor, one quotient bit per cycle.
`timescale 1ns / 1ps

module sss_divider #(
    parameter int DIVIDEND_W = 33,
    parameter int DIVISOR_W  = 17
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DIVIDEND_W-1:0] dividend,
    input  logic        [DIVISOR_W-1:0]  divisor,
    output logic                         done,
    output logic signed [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            neg_next  = dividend[DIVIDEND_W-1];
            dvs_next  = divisor;
            rem_next  = '0;
            quo_next  = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? DIVIDEND_W'(-$signed(quo_reg)) : $signed(quo_reg);

endmodule

### design/sss_datapath.sv
// Running min/max/sum/count, trapezoid area accumulator, mean divider and result register.
`timescale 1ns / 1ps

module sss_datapath #(
    parameter int MAX_SAMPLES = 65536,
    localparam int COUNT_W   = $clog2(MAX_SAMPLES + 1),
    localparam int RESULT_W  = 3 * sss_pkg::SAMPLE_W + sss_pkg::INTEGRAL_W
                               + sss_pkg::TIME_W + COUNT_W + 2,
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sss_pkg::cmd_t                       cmd,
    input  logic        [sss_pkg::TIME_W-1:0]   sample_time,
    input  logic signed [sss_pkg::SAMPLE_W-1:0] sample_value,
    output sss_pkg::status_t                    status,
    output logic        [M_TDATA_W-1:0]         result
);

    import sss_pkg::*;

    localparam int SUM_W  = SAMPLE_W + COUNT_W;
    localparam int PROD_W = SAMPLE_W + TIME_W + 2;
    localparam int AREA_W = INTEGRAL_W + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam logic signed [ACC_W-1:0] AREA_HI =
        {{(ACC_W - AREA_W + 1){1'b0}}, {(AREA_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] AREA_LO =
        {{(ACC_W - AREA_W + 1){1'b1}}, {(AREA_W - 1){1'b0}}};

    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;
    logic signed [SAMPLE_W-1:0] prev_value_reg, prev_value_next;
    logic        [TIME_W-1:0]   start_time_reg, start_time_next;
    logic        [TIME_W-1:0]   prev_time_reg, prev_time_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic        [COUNT_W-1:0]  count_reg, count_next;
    logic signed [AREA_W-1:0]   area_reg, area_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic                       prod_vld_reg, prod_vld_next;
    logic                       open_reg, open_next;
    logic                       too_long_reg, too_long_next;
    logic                       time_err_reg, time_err_next;
    logic [M_TDATA_W-1:0]       result_reg, result_next;

    logic                       time_ok;
    logic        [TIME_W-1:0]   dt;
    logic signed [SAMPLE_W:0]   pair_sum;
    logic signed [TIME_W:0]     dt_s;
    logic signed [ACC_W-1:0]    area_sum;
    logic        [TIME_W-1:0]   duration;
    logic                       div_done;
    logic signed [SUM_W-1:0]    quotient;

    assign time_ok  = (sample_time >= prev_time_reg);
    assign dt       = time_ok ? (sample_time - prev_time_reg) : '0;
    assign pair_sum = (SAMPLE_W + 1)'(prev_value_reg) + (SAMPLE_W + 1)'(sample_value);
    assign dt_s     = $signed({1'b0, dt});
    assign area_sum = ACC_W'(area_reg) + ACC_W'(prod_reg);
    assign duration = (prev_time_reg >= start_time_reg) ? (prev_time_reg - start_time_reg) : '0;

    sss_divider #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (COUNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.launch),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        min_next        = min_reg;
        max_next        = max_reg;
        prev_value_next = prev_value_reg;
        start_time_next = start_time_reg;
        prev_time_next  = prev_time_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        area_next       = area_reg;
        prod_next       = prod_reg;
        prod_vld_next   = 1'b0;
        open_next       = open_reg;
        too_long_next   = too_long_reg;
        time_err_next   = time_err_reg;
        result_next     = result_reg;

        if (prod_vld_reg)
        begin
            priority if (area_sum > AREA_HI)
                area_next = AREA_HI[AREA_W-1:0];
            else if (area_sum < AREA_LO)
                area_next = AREA_LO[AREA_W-1:0];
            else
                area_next = area_sum[AREA_W-1:0];
        end

        if (cmd.take)
        begin
            if (!open_reg)
            begin
                min_next        = sample_value;
                max_next        = sample_value;
                start_time_next = sample_time;
                open_next       = 1'b1;
            end
            else
            begin
                if (!time_ok)
                    time_err_next = 1'b1;
                if (sample_value < min_reg)
                    min_next = sample_value;
                if (sample_value > max_reg)
                    max_next = sample_value;
                prod_next     = PROD_W'(pair_sum) * PROD_W'(dt_s);
                prod_vld_next = 1'b1;
            end
            if (count_reg < COUNT_W'(MAX_SAMPLES))
            begin
                count_next = count_reg + COUNT_W'(1);
                sum_next   = sum_reg + SUM_W'(sample_value);
            end
            else
            begin
                too_long_next = 1'b1;
            end
            prev_time_next  = sample_time;
            prev_value_next = sample_value;
        end

        if (cmd.publish)
        begin
            result_next = M_TDATA_W'({time_err_reg, too_long_reg, count_reg, duration,
                                      area_reg[AREA_W-1:1], quotient[SAMPLE_W-1:0],
                                      max_reg, min_reg});
            open_next     = 1'b0;
            sum_next      = '0;
            count_next    = '0;
            area_next     = '0;
            too_long_next = 1'b0;
            time_err_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= '0;
            count_reg    <= '0;
            area_reg     <= '0;
            prod_vld_reg <= 1'b0;
            open_reg     <= 1'b0;
            too_long_reg <= 1'b0;
            time_err_reg <= 1'b0;
        end
        else
        begin
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            area_reg     <= area_next;
            prod_vld_reg <= prod_vld_next;
            open_reg     <= open_next;
            too_long_reg <= too_long_next;
            time_err_reg <= time_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg        <= min_next;
        max_reg        <= max_next;
        prev_value_reg <= prev_value_next;
        start_time_reg <= start_time_next;
        prev_time_reg  <= prev_time_next;
        prod_reg       <= prod_next;
        result_reg     <= result_next;
    end

    assign status.div_done = div_done;
    assign result          = result_reg;

endmodule

### design/sss_ctrl.sv
// Record controller: sample intake, division launch and result hand-off.
`timescale 1ns / 1ps

module sss_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tlast,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output sss_pkg::cmd_t    cmd,
    input  sss_pkg::status_t status
);

    import sss_pkg::*;

    localparam logic [1:0] ST_ACCUM   = 2'd0;
    localparam logic [1:0] ST_LAUNCH  = 2'd1;
    localparam logic [1:0] ST_DIVIDE  = 2'd2;
    localparam logic [1:0] ST_PUBLISH = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_ACCUM:
            begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
                if (s_tvalid && s_tlast)
                    state_next = ST_LAUNCH;
            end
            ST_LAUNCH:
            begin
                cmd.launch = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (status.div_done)
                    state_next = ST_PUBLISH;
            end
            ST_PUBLISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase

        out_valid_next = out_valid_reg && !m_tready;
        if (cmd.publish)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

### design/sample_sequence_statistics.sv
// Top level of the sample sequence statistics block (min, max, mean, trapezoid integral).
//
//   channel  | dir | handshake          | contents
//   s_*      | in  | s_tvalid/s_tready  | tdata: sample_time, sample_value; tlast: last_sample
//   m_*      | out | m_tvalid/m_tready  | tdata: min, max, mean, integral, duration, count, flags
//
// One sample beat per cycle inside a record. After the last beat of a record the
// input stalls through the launch, divide and publish states while the bit-serial
// mean divider runs, plus any wait for the result register to empty.
// A finished result sits in the output register while the next record streams in.
// Reset is asynchronous and returns the block to an empty record.
`timescale 1ns / 1ps

module sample_sequence_statistics #(
    parameter int MAX_SAMPLES = 65536,
    localparam int COUNT_W   = $clog2(MAX_SAMPLES + 1),
    localparam int RESULT_W  = 3 * sss_pkg::SAMPLE_W + sss_pkg::INTEGRAL_W
                               + sss_pkg::TIME_W + COUNT_W + 2,
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // sample_time, sample_value
    input  logic [sss_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // minimum, maximum, mean, integral, duration, sample_count, too_long, time_error
    output logic [M_TDATA_W-1:0]          m_tdata
);

    import sss_pkg::*;

    cmd_t                       cmd;
    status_t                    status;
    logic        [TIME_W-1:0]   sample_time;
    logic signed [SAMPLE_W-1:0] sample_value;

    assign sample_time  = s_tdata[TIME_W-1:0];
    assign sample_value = $signed(s_tdata[TIME_W +: SAMPLE_W]);

    sss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    sss_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sample_time  (sample_time),
        .sample_value (sample_value),
        .status       (status),
        .result       (m_tdata)
    );

endmodule

### design/sss_checker.sv
// Port-level checks for sample sequence statistics, bound to the top level.
`timescale 1ns / 1ps

module sss_checker #(
    parameter int MAX_SAMPLES = 65536,
    localparam int COUNT_W   = $clog2(MAX_SAMPLES + 1),
    localparam int RESULT_W  = 3 * sss_pkg::SAMPLE_W + sss_pkg::INTEGRAL_W
                               + sss_pkg::TIME_W + COUNT_W + 2,
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    import sss_pkg::*;

    localparam int COUNT_LSB = 3 * SAMPLE_W + INTEGRAL_W + TIME_W;

    logic signed [SAMPLE_W-1:0] r_min;
    logic signed [SAMPLE_W-1:0] r_max;
    logic signed [SAMPLE_W-1:0] r_mean;

    assign r_min  = $signed(m_tdata[0 +: SAMPLE_W]);
    assign r_max  = $signed(m_tdata[SAMPLE_W +: SAMPLE_W]);
    assign r_mean = $signed(m_tdata[2 * SAMPLE_W +: SAMPLE_W]);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input not held off after last beat");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast && !m_tvalid |=> !m_tvalid)
        else $error("result appeared without a last beat");

    a_result_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (r_min <= r_mean) && (r_mean <= r_max))
        else $error("mean outside min and max");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[COUNT_LSB +: COUNT_W] != '0)
        else $error("result with zero sample count");

endmodule

bind sample_sequence_statistics sss_checker #(
    .MAX_SAMPLES (MAX_SAMPLES)
) u_sss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
